[rtl/core/ilr_pkg.sv]
// ----------------------------------------------------------------------------
// ilr_pkg
// Shared types and constants of the inflight request limiter.
// ----------------------------------------------------------------------------
package ilr_pkg;

   // Width of the reported counts and of the limit registers
   localparam int CNT_W = 9;
   // Width of the timeout register and of the configuration data
   localparam int TMO_W = 16;
   // Width of the time stamp on the request port
   localparam int NOW_W = 32;
   // Lifetime used when the timeout register holds zero
   localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT = 16'd10;

   typedef enum logic [1:0] {
      OP_NOTE    = 2'd0,
      OP_ACK     = 2'd1,
      OP_RECOVER = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_SUBSCRIBE_LIMIT = 2'd0,
      CSR_DESCRIBE_LIMIT  = 2'd1,
      CSR_TIMEOUT         = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CMP,
      ST_RESP
   } state_type;

   // Commands from the sequencer to one deadline queue
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
      logic rd;
   } q_cmd_type;

endpackage

[rtl/core/ilr_ram.sv]
// ----------------------------------------------------------------------------
// ilr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ilr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ilr_queue.sv]
// ----------------------------------------------------------------------------
// ilr_queue
// One deadline queue: head and occupancy registers around a deadline RAM.
// ----------------------------------------------------------------------------
module ilr_queue #(
   parameter int DEPTH     = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ilr_pkg::q_cmd_type         cmd,
   input  logic [TIME_BITS-1:0]       push_data,
   output logic [TIME_BITS-1:0]       head_data,
   output logic [$clog2(DEPTH+1)-1:0] occ,
   output logic [$clog2(DEPTH+1)-1:0] occ_nxt,
   output logic                       at_depth
);

   localparam int AW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);
   localparam int SW = OW + 1;

   logic [AW-1:0] head_ff, head_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] tail_wrap;
   logic [AW-1:0] tail;
   logic          wr_en;

   // Tail is head plus occupancy, wrapped once
   assign tail_sum  = SW'(head_ff) + SW'(occ_ff);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? (tail_sum - SW'(DEPTH)) : tail_sum;
   assign tail      = tail_wrap[AW-1:0];
   assign at_depth  = (occ_ff == OW'(DEPTH));

   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      wr_en   = 1'b0;
      if (cmd.clear) begin
         head_in = '0;
         occ_in  = '0;
      end else if (cmd.push && !at_depth) begin
         wr_en  = 1'b1;
         occ_in = occ_ff + OW'(1);
      end else if (cmd.pop && (occ_ff != '0)) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
         occ_in  = occ_ff - OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
      end
   end

   ilr_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (push_data),
      .rd_en   (cmd.rd),
      .rd_addr (head_ff),
      .rd_data (head_data)
   );

   assign occ     = occ_ff;
   assign occ_nxt = occ_in;

endmodule

[rtl/core/inflight_request_limiter_unit.sv]
// ----------------------------------------------------------------------------
// inflight_request_limiter_unit
// Limits outstanding subscribe and describe requests with deadline queues.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake              word carries
//   req_*        in          req_valid/req_ready    operation, class, time
//   rsp_*        out         rsp_valid/rsp_ready    counts, full flags, drop
//   csr_*        in          csr_write_enable       limit or timeout value
//
// Note, ack and clear are accepted, then executed into the output register.
// Recover walks the subscribe queue, then the describe queue, until each is empty or
// its head survives; a head is read from its RAM, then compared and popped if expired.
// A stalled result holds in the output register; the next word is accepted and waits
// in execute, or for recover in response. Synchronous reset clears pointers and
// control; deadline RAMs are never cleared, since only written entries are ever read.
//
module inflight_request_limiter_unit #(
   parameter int DEPTH     = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic                        req_request_class,
   input  logic [ilr_pkg::NOW_W-1:0]   req_now_seconds,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ilr_pkg::CNT_W-1:0]   rsp_subscribe_count,
   output logic [ilr_pkg::CNT_W-1:0]   rsp_describe_count,
   output logic                        rsp_subscribe_full,
   output logic                        rsp_describe_full,
   output logic                        rsp_dropped,
   // configuration port
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [ilr_pkg::TMO_W-1:0]   csr_write_data
);

   localparam int OW = $clog2(DEPTH + 1);
   localparam int CW = (OW > ilr_pkg::CNT_W) ? OW : ilr_pkg::CNT_W;
   localparam int NW = (TIME_BITS > ilr_pkg::NOW_W) ? TIME_BITS : ilr_pkg::NOW_W;

   // Configuration registers
   logic [ilr_pkg::CNT_W-1:0] sub_limit_ff;
   logic [ilr_pkg::CNT_W-1:0] desc_limit_ff;
   logic [ilr_pkg::TMO_W-1:0] timeout_ff;

   // Held request word
   ilr_pkg::op_type      op_ff;
   logic                 cls_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [NW-1:0]        now_ext;

   // Sequencer
   ilr_pkg::state_type state_ff, state_in;
   logic               walk_cls_ff, walk_cls_in;

   // Result register
   logic                      rsp_valid_ff;
   logic [ilr_pkg::CNT_W-1:0] rsp_sub_cnt_ff;
   logic [ilr_pkg::CNT_W-1:0] rsp_desc_cnt_ff;
   logic                      rsp_sub_full_ff;
   logic                      rsp_desc_full_ff;
   logic                      rsp_drop_ff;

   // Queue interface
   ilr_pkg::q_cmd_type   sub_cmd, desc_cmd;
   logic [TIME_BITS-1:0] sub_head, desc_head, walk_head;
   logic [OW-1:0]        sub_occ, desc_occ, sub_occ_nxt, desc_occ_nxt;
   logic                 sub_at_depth, desc_at_depth;
   logic                 walk_empty;
   logic                 walk_expired;

   // Deadline computation
   logic [ilr_pkg::TMO_W-1:0] timeout_eff;
   logic [TIME_BITS:0]        deadline_sum;
   logic [TIME_BITS-1:0]      deadline;

   // Result assembly
   logic          slot_free;
   logic          load_rsp;
   logic          use_nxt;
   logic          drop_now;
   logic [OW-1:0] res_sub_occ, res_desc_occ;
   logic [CW-1:0] res_sub_ext, res_desc_ext;

   // ------------------------------------------------------------------------
   // Configuration writes: only the addressed register changes
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_limit_ff  <= '0;
         desc_limit_ff <= '0;
         timeout_ff    <= ilr_pkg::DEFAULT_TIMEOUT;
      end else if (csr_write_enable) begin
         case (ilr_pkg::csr_index_type'(csr_index))
            ilr_pkg::CSR_SUBSCRIBE_LIMIT: begin
               sub_limit_ff <= csr_write_data[ilr_pkg::CNT_W-1:0];
            end
            ilr_pkg::CSR_DESCRIBE_LIMIT: begin
               desc_limit_ff <= csr_write_data[ilr_pkg::CNT_W-1:0];
            end
            ilr_pkg::CSR_TIMEOUT: begin
               timeout_ff <= csr_write_data;
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Capture the request word on acceptance
   // ------------------------------------------------------------------------
   assign now_ext = NW'(req_now_seconds);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= ilr_pkg::op_type'(req_operation);
         cls_ff <= req_request_class;
         now_ff <= now_ext[TIME_BITS-1:0];
      end
   end

   // Deadline is now plus timeout, saturating at the top of the time range
   assign timeout_eff  = (timeout_ff == '0) ? ilr_pkg::DEFAULT_TIMEOUT : timeout_ff;
   assign deadline_sum = {1'b0, now_ff} + (TIME_BITS + 1)'(timeout_eff);
   assign deadline     = deadline_sum[TIME_BITS] ? '1 : deadline_sum[TIME_BITS-1:0];

   // Expiry walk looks at one queue head at a time
   assign walk_head    = walk_cls_ff ? desc_head : sub_head;
   assign walk_empty   = walk_cls_ff ? (desc_occ == '0) : (sub_occ == '0);
   assign walk_expired = (walk_head <= now_ff);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      walk_cls_in = walk_cls_ff;
      case (state_ff)
         ilr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ilr_pkg::ST_EXEC;
            end
         end
         ilr_pkg::ST_EXEC: begin
            if (op_ff == ilr_pkg::OP_RECOVER) begin
               state_in    = ilr_pkg::ST_READ;
               walk_cls_in = 1'b0;
            end else if (slot_free) begin
               state_in = ilr_pkg::ST_IDLE;
            end
         end
         ilr_pkg::ST_READ: begin
            if (!walk_empty) begin
               state_in = ilr_pkg::ST_CMP;
            end else if (walk_cls_ff) begin
               state_in = ilr_pkg::ST_RESP;
            end else begin
               walk_cls_in = 1'b1;
            end
         end
         ilr_pkg::ST_CMP: begin
            if (walk_expired) begin
               state_in = ilr_pkg::ST_READ;
            end else if (walk_cls_ff) begin
               state_in = ilr_pkg::ST_RESP;
            end else begin
               state_in    = ilr_pkg::ST_READ;
               walk_cls_in = 1'b1;
            end
         end
         ilr_pkg::ST_RESP: begin
            if (slot_free) begin
               state_in = ilr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ilr_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      sub_cmd   = '0;
      desc_cmd  = '0;
      load_rsp  = 1'b0;
      use_nxt   = 1'b0;
      drop_now  = 1'b0;
      case (state_ff)
         ilr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ilr_pkg::ST_EXEC: begin
            // Execute once, when the result can be loaded in the same cycle
            if (op_ff != ilr_pkg::OP_RECOVER && slot_free) begin
               load_rsp = 1'b1;
               use_nxt  = 1'b1;
               case (op_ff)
                  ilr_pkg::OP_NOTE: begin
                     sub_cmd.push  = !cls_ff;
                     desc_cmd.push = cls_ff;
                     drop_now      = cls_ff ? desc_at_depth : sub_at_depth;
                  end
                  ilr_pkg::OP_ACK: begin
                     sub_cmd.pop  = !cls_ff;
                     desc_cmd.pop = cls_ff;
                  end
                  ilr_pkg::OP_CLEAR: begin
                     sub_cmd.clear  = 1'b1;
                     desc_cmd.clear = 1'b1;
                  end
                  default: begin
                     // recover takes the walk instead
                  end
               endcase
            end
         end
         ilr_pkg::ST_READ: begin
            sub_cmd.rd  = !walk_cls_ff && !walk_empty;
            desc_cmd.rd = walk_cls_ff && !walk_empty;
         end
         ilr_pkg::ST_CMP: begin
            sub_cmd.pop  = !walk_cls_ff && walk_expired;
            desc_cmd.pop = walk_cls_ff && walk_expired;
         end
         ilr_pkg::ST_RESP: begin
            load_rsp = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ilr_pkg::ST_IDLE;
         walk_cls_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         walk_cls_ff <= walk_cls_in;
      end
   end

   // ------------------------------------------------------------------------
   // Deadline queues
   // ------------------------------------------------------------------------
   ilr_queue #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_sub_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (sub_cmd),
      .push_data (deadline),
      .head_data (sub_head),
      .occ       (sub_occ),
      .occ_nxt   (sub_occ_nxt),
      .at_depth  (sub_at_depth)
   );

   ilr_queue #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_desc_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (desc_cmd),
      .push_data (deadline),
      .head_data (desc_head),
      .occ       (desc_occ),
      .occ_nxt   (desc_occ_nxt),
      .at_depth  (desc_at_depth)
   );

   // ------------------------------------------------------------------------
   // Result register: counts after the operation, full against the limits
   // ------------------------------------------------------------------------
   assign res_sub_occ  = use_nxt ? sub_occ_nxt : sub_occ;
   assign res_desc_occ = use_nxt ? desc_occ_nxt : desc_occ;
   assign res_sub_ext  = CW'(res_sub_occ);
   assign res_desc_ext = CW'(res_desc_occ);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sub_cnt_ff   <= res_sub_ext[ilr_pkg::CNT_W-1:0];
         rsp_desc_cnt_ff  <= res_desc_ext[ilr_pkg::CNT_W-1:0];
         rsp_sub_full_ff  <= (sub_limit_ff != '0) && (res_sub_ext >= CW'(sub_limit_ff));
         rsp_desc_full_ff <= (desc_limit_ff != '0) && (res_desc_ext >= CW'(desc_limit_ff));
         rsp_drop_ff      <= drop_now;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_subscribe_count = rsp_sub_cnt_ff;
   assign rsp_describe_count  = rsp_desc_cnt_ff;
   assign rsp_subscribe_full  = rsp_sub_full_ff;
   assign rsp_describe_full   = rsp_desc_full_ff;
   assign rsp_dropped         = rsp_drop_ff;

endmodule
